FILE: rtl/core/thwma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thwma_pkg
// Shared widths, codes, reset values and types of the thermostat with a
// moving-average temperature estimate.
// ----------------------------------------------------------------------------
package thwma_pkg;

	localparam int KIND_W     = 3;
	localparam int SP_W       = 7;
	localparam int STEP_W     = 4;
	localparam int BAND_W     = 5;
	localparam int TMO_W      = 3;
	localparam int TEMP_W     = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// degrees = reading * 12 / 25
	localparam int SCALE_NUM = 12;
	localparam int SCALE_DEN = 25;

	localparam logic [SP_W-1:0]   MIN_SETPOINT_RST  = 7'd35;
	localparam logic [SP_W-1:0]   MAX_SETPOINT_RST  = 7'd75;
	localparam logic [STEP_W-1:0] STEP_RST          = 4'd5;
	localparam logic [BAND_W-1:0] BAND_RST          = 5'd5;
	localparam logic [TMO_W-1:0]  TIMEOUT_RST       = 3'd5;
	localparam logic [SP_W-1:0]   INIT_SETPOINT_RST = 7'd60;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 3'd0,
		KIND_SECOND = 3'd1,
		KIND_UP     = 3'd2,
		KIND_DOWN   = 3'd3,
		KIND_POWER  = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SETPOINT     = 3'd0,
		REG_MAX_SETPOINT     = 3'd1,
		REG_SETPOINT_STEP    = 3'd2,
		REG_BAND             = 3'd3,
		REG_MODE_TIMEOUT     = 3'd4,
		REG_INITIAL_SETPOINT = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [SP_W-1:0]   min_setpoint;
		logic [SP_W-1:0]   max_setpoint;
		logic [STEP_W-1:0] setpoint_step;
		logic [BAND_W-1:0] band;
		logic [TMO_W-1:0]  mode_timeout;
	} cfg_t;

	typedef struct packed {
		logic              heater_on;
		logic              cooler_on;
		logic              power_on;
		logic              in_setting_mode;
		logic [TEMP_W-1:0] average_temp;
		logic [TEMP_W-1:0] display_value;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/core/thwma_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thwma_if
// Valid/ready channels of the thermostat: event requests in, results out.
// ----------------------------------------------------------------------------
interface thwma_event_if import thwma_pkg::*; #(
	parameter int ADC_BITS = 10
) ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ADC_BITS-1:0] adc_value;

	modport source (output valid, output kind, output adc_value, input ready);
	modport sink   (input valid, input kind, input adc_value, output ready);
endinterface

interface thwma_result_if import thwma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              heater_on;
	logic              cooler_on;
	logic              power_on;
	logic              in_setting_mode;
	logic [TEMP_W-1:0] average_temp;
	logic [TEMP_W-1:0] display_value;

	modport source (output valid, output heater_on, output cooler_on, output power_on,
		output in_setting_mode, output average_temp, output display_value, input ready);
	modport sink   (input valid, input heater_on, input cooler_on, input power_on,
		input in_setting_mode, input average_temp, input display_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/thwma_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thwma_cell
// One slot of the sample window: takes its left neighbor's sample on a shift.
// ----------------------------------------------------------------------------
module thwma_cell #(
	parameter int W = 9
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule
`default_nettype wire

FILE: rtl/core/thwma_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thwma_window
// Row of sample cells with a running sum: the newest sample enters cell 0,
// the one leaving the last cell is taken out of the sum.
// ----------------------------------------------------------------------------
module thwma_window #(
	parameter int WINDOW = 10,
	parameter int DEG_W  = 9,
	parameter int SUM_W  = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic [DEG_W-1:0] deg,
	output logic [SUM_W-1:0] sum
);

	logic [DEG_W-1:0] tap [WINDOW];
	logic [SUM_W-1:0] sum_q;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			thwma_cell #(.W(DEG_W)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (deg),
				.q      (tap[i])
			);
		end else begin : g_body
			thwma_cell #(.W(DEG_W)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (tap[i-1]),
				.q      (tap[i])
			);
		end
	end

	// intermediate may wrap; the final sum always fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_q - SUM_W'(tap[WINDOW-1]) + SUM_W'(deg);
		end
	end

	assign sum = sum_q;

endmodule
`default_nettype wire

FILE: rtl/core/thwma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thwma_ctrl
// Control state: power, setting mode, heater/cooler drive, setpoint and the
// seconds counter. Its registers double as the result register.
// ----------------------------------------------------------------------------
module thwma_ctrl import thwma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kind_t             kind,
	input  logic [TEMP_W-1:0] avg,
	input  cfg_t              cfg,
	output result_t           res
);

	logic              power_q, setting_q, heater_q, cooler_q;
	logic [SP_W-1:0]   sp_q;
	logic [TMO_W-1:0]  cnt_q;
	logic [TEMP_W-1:0] avg_q;

	logic              power_d, setting_d, heater_d, cooler_d;
	logic [SP_W-1:0]   sp_d;
	logic [TMO_W-1:0]  cnt_d;
	logic [TEMP_W-1:0] avg_d;

	logic [TEMP_W:0]   heat_lvl, cool_lvl;
	logic [TMO_W-1:0]  cnt_inc;
	logic [SP_W:0]     up_sum;
	logic [SP_W-1:0]   down_gap;

	assign heat_lvl = (TEMP_W+1)'(avg) + (TEMP_W+1)'(cfg.band);
	assign cool_lvl = (TEMP_W+1)'(sp_q) + (TEMP_W+1)'(cfg.band);
	assign cnt_inc  = cnt_q + TMO_W'(1);
	assign up_sum   = (SP_W+1)'(sp_q) + (SP_W+1)'(cfg.setpoint_step);
	assign down_gap = sp_q - cfg.min_setpoint;

	always_comb begin
		power_d   = power_q;
		setting_d = setting_q;
		heater_d  = heater_q;
		cooler_d  = cooler_q;
		sp_d      = sp_q;
		cnt_d     = cnt_q;
		avg_d     = avg_q;
		case (kind)
			KIND_SAMPLE: begin
				avg_d = avg;
				if (power_q) begin
					// heater wins when both thresholds are met
					if (heat_lvl <= (TEMP_W+1)'(sp_q)) begin
						heater_d = 1'b1;
						cooler_d = 1'b0;
					end else if ((TEMP_W+1)'(avg) >= cool_lvl) begin
						heater_d = 1'b0;
						cooler_d = 1'b1;
					end
				end
			end
			KIND_SECOND: begin
				if (setting_q) begin
					if (cnt_inc >= cfg.mode_timeout) begin
						setting_d = 1'b0;
						cnt_d     = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			KIND_UP: begin
				if (power_q) begin
					cnt_d = '0;
					if (!setting_q) begin
						setting_d = 1'b1;
					end else if (sp_q < cfg.max_setpoint) begin
						sp_d = (up_sum > (SP_W+1)'(cfg.max_setpoint)) ? cfg.max_setpoint
							: up_sum[SP_W-1:0];
					end
				end
			end
			KIND_DOWN: begin
				if (power_q) begin
					cnt_d = '0;
					if (!setting_q) begin
						setting_d = 1'b1;
					end else if (sp_q > cfg.min_setpoint) begin
						sp_d = (down_gap > SP_W'(cfg.setpoint_step))
							? sp_q - SP_W'(cfg.setpoint_step) : cfg.min_setpoint;
					end
				end
			end
			KIND_POWER: begin
				if (power_q) begin
					power_d   = 1'b0;
					setting_d = 1'b0;
					heater_d  = 1'b0;
					cooler_d  = 1'b0;
					cnt_d     = '0;
				end else begin
					power_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q   <= 1'b0;
			setting_q <= 1'b0;
			heater_q  <= 1'b0;
			cooler_q  <= 1'b0;
			sp_q      <= INIT_SETPOINT_RST;
			cnt_q     <= '0;
			avg_q     <= '0;
		end else if (load) begin
			power_q   <= power_d;
			setting_q <= setting_d;
			heater_q  <= heater_d;
			cooler_q  <= cooler_d;
			sp_q      <= sp_d;
			cnt_q     <= cnt_d;
			avg_q     <= avg_d;
		end
	end

	always_comb begin
		res.heater_on       = heater_q;
		res.cooler_on       = cooler_q;
		res.power_on        = power_q;
		res.in_setting_mode = setting_q;
		res.average_temp    = avg_q;
		if (!power_q) begin
			res.display_value = '0;
		end else if (setting_q) begin
			res.display_value = TEMP_W'(sp_q);
		end else begin
			res.display_value = avg_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/thermostat_with_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermostat_with_moving_average
// Hysteresis thermostat driven by a moving average of scaled readings.
// ----------------------------------------------------------------------------
// Takes one event request per clock (sample, second tick, up, down, power) while
// no stage is stalled, and returns one result per event from the result register.
// The rate of one per cycle is set by the running-sum
// update of the sample window, a row of WINDOW cells that shift once per
// sample. Stage 1 scales the reading by 12/25 with a reciprocal multiply,
// stage 2 shifts the window and updates the sum, stage 3 multiplies the sum by
// the reciprocal of WINDOW, and the control registers, which form the result
// register, take the event last. Each stage holds only while the one after it
// is full and stalled. Configuration writes are meant for idle periods; a write
// of initial_setpoint has no effect, since reset restores it to its default.
// ----------------------------------------------------------------------------
module thermostat_with_moving_average import thwma_pkg::*; #(
	parameter int WINDOW   = 10,
	parameter int ADC_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	thwma_event_if.sink           events,
	thwma_result_if.source        results
);

	// scaling: x = reading * 12, exact x / 25 by reciprocal
	localparam int XW  = ADC_BITS + 4;
	localparam int S1  = XW + $clog2(SCALE_DEN);
	localparam longint unsigned M1 =
		((64'd1 << S1) + 64'(SCALE_DEN) - 64'd1) / 64'(SCALE_DEN);
	localparam int PW1 = XW + XW + 1;

	localparam int DEG_MAX = ((2 ** ADC_BITS - 1) * SCALE_NUM) / SCALE_DEN;
	localparam int DEG_W   = $clog2(DEG_MAX + 1);
	localparam int SUM_W   = $clog2(WINDOW * DEG_MAX + 1);

	// averaging: exact sum / WINDOW by reciprocal
	localparam int S2  = SUM_W + $clog2(WINDOW);
	localparam longint unsigned M2 =
		((64'd1 << S2) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam int PW2 = SUM_W + SUM_W + 1;

	cfg_t cfg_q;

	logic            en1, en2, en3, take_o;
	logic            v_s1, v_s2, v_s3, out_valid_q;
	kind_t           kind_s1, kind_s2, kind_s3;
	logic [PW1-1:0]  prod_s1;
	logic [PW2-1:0]  prod_s3;

	logic [XW-1:0]    scaled_x;
	logic [PW1-1:0]   deg_shift;
	logic [DEG_W-1:0] deg;
	logic [SUM_W-1:0] sum;
	logic [PW2-1:0]   avg_shift;
	logic             win_shift;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_setpoint  <= MIN_SETPOINT_RST;
			cfg_q.max_setpoint  <= MAX_SETPOINT_RST;
			cfg_q.setpoint_step <= STEP_RST;
			cfg_q.band          <= BAND_RST;
			cfg_q.mode_timeout  <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_MIN_SETPOINT:     cfg_q.min_setpoint  <= wr_data[SP_W-1:0];
				REG_MAX_SETPOINT:     cfg_q.max_setpoint  <= wr_data[SP_W-1:0];
				REG_SETPOINT_STEP:    cfg_q.setpoint_step <= wr_data[STEP_W-1:0];
				REG_BAND:             cfg_q.band          <= wr_data[BAND_W-1:0];
				REG_MODE_TIMEOUT:     cfg_q.mode_timeout  <= wr_data[TMO_W-1:0];
				REG_INITIAL_SETPOINT: ;
				default: ;
			endcase
		end
	end

	// stall chain: a stage moves when the next one is empty or moving
	assign take_o = !out_valid_q || results.ready;
	assign en3    = !v_s3 || take_o;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign events.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= events.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (take_o) out_valid_q <= v_s3;
		end
	end

	assign scaled_x = XW'({events.adc_value, 3'b000}) + XW'({events.adc_value, 2'b00});

	always_ff @(posedge clk) begin
		if (en1 && events.valid) begin
			kind_s1 <= kind_t'(events.kind);
			prod_s1 <= PW1'(scaled_x) * PW1'(M1);
		end
		if (en2 && v_s1) begin
			kind_s2 <= kind_s1;
		end
		// sum already holds the value left by the request in stage 2
		if (en3 && v_s2) begin
			kind_s3 <= kind_s2;
			prod_s3 <= PW2'(sum) * PW2'(M2);
		end
	end

	assign deg_shift = prod_s1 >> S1;
	assign deg       = deg_shift[DEG_W-1:0];
	assign win_shift = v_s1 && en2 && (kind_s1 == KIND_SAMPLE);

	thwma_window #(
		.WINDOW (WINDOW),
		.DEG_W  (DEG_W),
		.SUM_W  (SUM_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (win_shift),
		.deg    (deg),
		.sum    (sum)
	);

	assign avg_shift = prod_s3 >> S2;

	thwma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (v_s3 && take_o),
		.kind   (kind_s3),
		.avg    (avg_shift[TEMP_W-1:0]),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign results.valid           = out_valid_q;
	assign results.heater_on       = res.heater_on;
	assign results.cooler_on       = res.cooler_on;
	assign results.power_on        = res.power_on;
	assign results.in_setting_mode = res.in_setting_mode;
	assign results.average_temp    = res.average_temp;
	assign results.display_value   = res.display_value;

endmodule
`default_nettype wire

FILE: rtl/core/thwma_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thwma_checker
// Port-level checks on the result channel of the thermostat.
// ----------------------------------------------------------------------------
module thwma_checker import thwma_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              valid,
	input wire logic              ready,
	input wire logic              heater_on,
	input wire logic              cooler_on,
	input wire logic              power_on,
	input wire logic              in_setting_mode,
	input wire logic [TEMP_W-1:0] average_temp,
	input wire logic [TEMP_W-1:0] display_value
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(heater_on) && $stable(cooler_on)
			&& $stable(power_on) && $stable(in_setting_mode)
			&& $stable(average_temp) && $stable(display_value))
		else $error("stalled result changed");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !(heater_on && cooler_on))
		else $error("heater and cooler both on");

	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !power_on |-> !heater_on && !cooler_on && !in_setting_mode
			&& display_value == '0)
		else $error("unit off but drives or display active");

	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		valid && power_on && !in_setting_mode |-> display_value == average_temp)
		else $error("display does not show the average");

endmodule

bind thermostat_with_moving_average thwma_checker u_thwma_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.valid           (results.valid),
	.ready           (results.ready),
	.heater_on       (results.heater_on),
	.cooler_on       (results.cooler_on),
	.power_on        (results.power_on),
	.in_setting_mode (results.in_setting_mode),
	.average_temp    (results.average_temp),
	.display_value   (results.display_value)
);
`default_nettype wire

FILE: test/tb_thermostat_with_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermostat_with_moving_average
// Self-checking bench for the moving-average thermostat. Event requests go in
// with random gaps, results are drained with random stalls, and a scoreboard
// that models the window, setpoint and hysteresis logic checks every result.
// ----------------------------------------------------------------------------

import thwma_pkg::*;

class thermostat_scoreboard;
	localparam int WINDOW_LEN = 10;

	logic [SP_W-1:0]   min_sp;
	logic [SP_W-1:0]   max_sp;
	logic [STEP_W-1:0] step;
	logic [BAND_W-1:0] band;
	logic [TMO_W-1:0]  timeout;

	logic [TEMP_W-1:0] window [WINDOW_LEN];
	int unsigned       window_total;
	int unsigned       slot;
	logic [TEMP_W-1:0] average;
	logic [SP_W-1:0]   setpoint;
	logic [TMO_W-1:0]  seconds;
	bit                power;
	bit                setting;
	bit                heater;
	bit                cooler;

	result_t           awaited [$];
	int                failures;

	function new();
		min_sp       = MIN_SETPOINT_RST;
		max_sp       = MAX_SETPOINT_RST;
		step         = STEP_RST;
		band         = BAND_RST;
		timeout      = TIMEOUT_RST;
		foreach (window[i]) window[i] = '0;
		window_total = 0;
		slot         = 0;
		average      = '0;
		setpoint     = INIT_SETPOINT_RST;
		seconds      = '0;
		power        = 0;
		setting      = 0;
		heater       = 0;
		cooler       = 0;
		failures     = 0;
	endfunction

	function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MIN_SETPOINT:  min_sp  = data[SP_W-1:0];
			REG_MAX_SETPOINT:  max_sp  = data[SP_W-1:0];
			REG_SETPOINT_STEP: step    = data[STEP_W-1:0];
			REG_BAND:          band    = data[BAND_W-1:0];
			REG_MODE_TIMEOUT:  timeout = data[TMO_W-1:0];
			// initial setpoint only matters at reset, which never comes again
			default: ;
		endcase
	endfunction

	function void take_reading(logic [9:0] adc);
		int unsigned deg;
		deg = (int'(adc) * SCALE_NUM) / SCALE_DEN;
		window_total = window_total - window[slot] + deg;
		window[slot] = deg[TEMP_W-1:0];
		slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
		average = TEMP_W'(window_total / WINDOW_LEN);
		if (power) begin
			// heater wins when both thresholds hold
			if (int'(average) + int'(band) <= int'(setpoint)) begin
				heater = 1;
				cooler = 0;
			end else if (int'(average) >= int'(setpoint) + int'(band)) begin
				cooler = 1;
				heater = 0;
			end
		end
	endfunction

	function void press(bit up);
		if (!power) return;
		seconds = '0;
		if (!setting) begin
			setting = 1;
			return;
		end
		if (up) begin
			if (setpoint < max_sp)
				setpoint = (int'(setpoint) + int'(step) > int'(max_sp))
					? max_sp : setpoint + SP_W'(step);
		end else begin
			if (setpoint > min_sp)
				setpoint = (int'(setpoint) - int'(min_sp) > int'(step))
					? setpoint - SP_W'(step) : min_sp;
		end
	endfunction

	function void note_event(logic [KIND_W-1:0] kind, logic [9:0] adc);
		result_t r;
		case (kind)
			KIND_SAMPLE: take_reading(adc);
			KIND_SECOND: begin
				if (setting) begin
					seconds = seconds + TMO_W'(1);
					if (seconds >= timeout) begin
						setting = 0;
						seconds = '0;
					end
				end
			end
			KIND_UP:     press(1);
			KIND_DOWN:   press(0);
			KIND_POWER: begin
				if (power) begin
					power   = 0;
					setting = 0;
					heater  = 0;
					cooler  = 0;
					seconds = '0;
				end else begin
					power = 1;
				end
			end
			default: ;
		endcase
		r.heater_on       = heater;
		r.cooler_on       = cooler;
		r.power_on        = power;
		r.in_setting_mode = setting;
		r.average_temp    = average;
		if (!power)
			r.display_value = '0;
		else if (setting)
			r.display_value = {{(TEMP_W-SP_W){1'b0}}, setpoint};
		else
			r.display_value = average;
		awaited.push_back(r);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (awaited.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("%0t: unexpected result h=%0b c=%0b p=%0b s=%0b avg=%0d disp=%0d",
					$time, got.heater_on, got.cooler_on, got.power_on,
					got.in_setting_mode, got.average_temp, got.display_value);
			return;
		end
		want = awaited.pop_front();
		if (got.heater_on !== want.heater_on || got.cooler_on !== want.cooler_on ||
			got.power_on !== want.power_on || got.in_setting_mode !== want.in_setting_mode ||
			got.average_temp !== want.average_temp ||
			got.display_value !== want.display_value) begin
			failures++;
			if (failures <= 10) begin
				$display("%0t: mismatch exp h=%0b c=%0b p=%0b s=%0b avg=%0d disp=%0d",
					$time, want.heater_on, want.cooler_on, want.power_on,
					want.in_setting_mode, want.average_temp, want.display_value);
				$display("%0t:          got h=%0b c=%0b p=%0b s=%0b avg=%0d disp=%0d",
					$time, got.heater_on, got.cooler_on, got.power_on,
					got.in_setting_mode, got.average_temp, got.display_value);
			end
		end
	endfunction
endclass

module tb_thermostat_with_moving_average;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 250;
	localparam logic [KIND_W-1:0] KIND_TOP = '1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bit no_idle = 0;
	bit unit_on = 0;
	int cycle_count = 0;

	thermostat_scoreboard sb = new();

	thwma_event_if #(.ADC_BITS(10)) ev_if ();
	thwma_result_if res_if ();

	thermostat_with_moving_average #(
		.WINDOW(10),
		.ADC_BITS(10)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.events(ev_if.sink),
		.results(res_if.source)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// note requests before results so a same-edge pair stays ordered
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (ev_if.valid && ev_if.ready)
				sb.note_event(ev_if.kind, ev_if.adc_value);
			if (res_if.valid && res_if.ready) begin
				got.heater_on       = res_if.heater_on;
				got.cooler_on       = res_if.cooler_on;
				got.power_on        = res_if.power_on;
				got.in_setting_mode = res_if.in_setting_mode;
				got.average_temp    = res_if.average_temp;
				got.display_value   = res_if.display_value;
				sb.check_result(got);
			end
		end
	end

	initial begin
		int stall;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.write_register(idx, data);
	endtask

	task automatic apply_config(int lo, int hi, int stp, int bnd, int tmo, int init);
		write_reg(REG_MIN_SETPOINT, lo);
		write_reg(REG_MAX_SETPOINT, hi);
		write_reg(REG_SETPOINT_STEP, stp);
		write_reg(REG_BAND, bnd);
		write_reg(REG_MODE_TIMEOUT, tmo);
		write_reg(REG_INITIAL_SETPOINT, init);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_event(logic [KIND_W-1:0] kind, logic [9:0] adc);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			ev_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev_if.valid     <= 1'b1;
		ev_if.kind      <= kind;
		ev_if.adc_value <= adc;
		do @(posedge clk); while (!ev_if.ready);
		if (kind == KIND_POWER) unit_on = !unit_on;
	endtask

	// drop valid and wait until every result is back, then let the pipe settle
	task automatic drain();
		ev_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random(int count);
		int sent;
		int r;
		int n;
		sent = 0;
		if (!unit_on) send_event(KIND_POWER, $urandom);
		while (sent < count) begin
			if (sent % 64 == 0) no_idle = ($urandom_range(0, 9) < 3);
			r = $urandom_range(0, 99);
			if (!unit_on && $urandom_range(0, 3) == 0) begin
				send_event(KIND_POWER, $urandom);
				sent++;
			end else if (r < 25) begin
				send_event(KIND_SAMPLE, $urandom_range(0, 1023));
				sent++;
			end else if (r < 50) begin
				// readings that land near typical setpoints
				send_event(KIND_SAMPLE, $urandom_range(40, 200));
				sent++;
			end else if (r < 65) begin
				n = $urandom_range(1, 8);
				repeat (n) send_event(KIND_SECOND, $urandom);
				sent += n;
			end else if (r < 94) begin
				n = $urandom_range(1, 4);
				repeat (n) send_event($urandom_range(0, 1) ? KIND_UP : KIND_DOWN, $urandom);
				sent += n;
			end else if (r < 97) begin
				send_event(KIND_POWER, $urandom);
				sent++;
			end else begin
				send_event($urandom_range(int'(KIND_POWER) + 1, int'(KIND_TOP)), $urandom);
				sent++;
			end
		end
		no_idle = 0;
	endtask

	initial begin
		int lo;
		int hi;
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= '0;
		wr_data         <= '0;
		ev_if.valid     <= 1'b0;
		ev_if.kind      <= KIND_SAMPLE;
		ev_if.adc_value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// band zero so that an average equal to the setpoint meets both thresholds
		apply_config(35, 75, 5, 0, 5, 60);
		send_event(KIND_SAMPLE, 10'd1023);
		send_event(KIND_UP, '0);
		send_event(KIND_DOWN, '0);
		send_event(KIND_SECOND, '0);
		send_event(KIND_TOP, 10'h3ff);
		send_event(KIND_POWER, '0);
		send_event(KIND_SAMPLE, 10'd1023);
		send_event(KIND_SAMPLE, 10'd1023);
		// ten readings of 60 degrees bring the average onto the setpoint
		repeat (10) send_event(KIND_SAMPLE, 10'd125);
		send_event(KIND_SAMPLE, 10'd0);
		send_event(KIND_UP, '0);
		repeat (4) send_event(KIND_UP, '0);
		send_event(KIND_DOWN, '0);
		repeat (5) send_event(KIND_SECOND, '0);
		send_event(KIND_POWER, '0);
		drain();

		apply_config(MIN_SETPOINT_RST, MAX_SETPOINT_RST, STEP_RST, BAND_RST, TIMEOUT_RST,
			INIT_SETPOINT_RST);
		run_random(RANDOM_PER_PHASE);
		drain();

		apply_config(0, 127, 15, 31, 7, 127);
		run_random(RANDOM_PER_PHASE);
		drain();

		apply_config(0, 127, 1, 0, 1, 0);
		run_random(RANDOM_PER_PHASE);
		drain();

		// timeout of zero ends setting mode on the first tick
		apply_config(60, 60, 15, 2, 0, 60);
		write_reg(REG_SPARE_A, $urandom_range(0, 127));
		write_reg(REG_SPARE_B, $urandom_range(0, 127));
		wr_en <= 1'b0;
		@(posedge clk);
		run_random(RANDOM_PER_PHASE);
		drain();

		// inverted limits
		apply_config(100, 20, 7, 10, 3, 85);
		run_random(RANDOM_PER_PHASE);
		drain();

		repeat (2) begin
			lo = $urandom_range(0, 80);
			hi = $urandom_range(lo, 127);
			apply_config(lo, hi, $urandom_range(1, 15), $urandom_range(0, 31),
				$urandom_range(1, 7), $urandom_range(0, 127));
			run_random(RANDOM_PER_PHASE);
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.awaited.size() == 0 && sb.failures == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
